// ----- rtl/core/queued_saturating_pcm_mixer_assert.svh -----
// assertion macros shared by the mixer rtl
// no dependencies; included by the files that carry checks
`ifndef QUEUED_SATURATING_PCM_MIXER_ASSERT_SVH
`define QUEUED_SATURATING_PCM_MIXER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define QSPM_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |-> (CONS)) \
		else $error("qspm check failed");

// next-cycle implication, reset masks the check
`define QSPM_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS) \
	LABEL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANTE) |=> (CONS)) \
		else $error("qspm check failed");

`endif

// ----- rtl/core/qspm_pkg.sv -----
// shared types and constants of the queued saturating pcm mixer
// no dependencies; imported by the mac unit and the top level
`default_nettype none

package qspm_pkg;

	// sample and gain formats
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned GAIN_W    = 16;
	localparam int unsigned GAIN_FRAC = 12;
	localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	// configuration registers
	localparam int unsigned GAIN_REGS  = 4;
	localparam int unsigned GAIN_IDX_W = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

	// item opcodes
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_MIX   = 2'd1;
	localparam logic [1:0] OP_FLUSH = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DISABLED = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;

	// sequencer controls for the shared multiply-accumulate unit
	typedef struct packed {
		logic acc_clr;
		logic mul_en;
		logic acc_en;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/queued_saturating_pcm_mixer.sv -----
// queued saturating pcm mixer: per-source queues in one ram, one shared mac unit
// push passes through a write state before done; flush and unused opcodes go straight to done
// mix scans every source in order; each enabled, non-empty source costs a ram read,
// a multiply and an accumulate step; new items stall while the sequencer is busy
// reset: queues empty, gains at unity, all sources disabled, no result pending
// queue ram contents are not cleared; only written entries are ever read
`default_nettype none
`include "queued_saturating_pcm_mixer_assert.svh"

module queued_saturating_pcm_mixer
	import qspm_pkg::*;
#(
	parameter int unsigned NUM_SOURCES = 4,
	parameter int unsigned QUEUE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// items
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [1:0]            opcode,
	input  logic [1:0]            source_index,
	input  sample_t               sample_in,
	// results
	output logic                  result_valid,
	input  logic                  result_stall,
	output sample_t               mixed_sample,
	output logic [1:0]            status
);

	localparam int unsigned NUM_ACT   = (NUM_SOURCES < GAIN_REGS) ? NUM_SOURCES : GAIN_REGS;
	localparam int unsigned IDX_W     = (NUM_ACT > 1) ? $clog2(NUM_ACT) : 1;
	localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SUM_W     = CNT_W + 1;
	localparam int unsigned MEM_DEPTH = NUM_ACT * QUEUE_DEPTH;
	localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ACT - 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PUSH = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_ADD  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]         state_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [1:0]         op_q;
	logic [1:0]         src_q;
	sample_t            smp_q;
	logic [1:0]         res_status_q;
	logic               result_valid_q;
	sample_t            mixed_q;
	logic [1:0]         status_q;
	logic [GAIN_W-1:0]  gain_q [GAIN_REGS];
	logic [GAIN_REGS-1:0] enable_q;
	logic [PTR_W-1:0]   rp_q   [NUM_ACT];
	logic [CNT_W-1:0]   fill_q [NUM_ACT];

	logic               item_accept;
	logic               cfg_accept;
	logic               enable_write;
	logic [GAIN_REGS-1:0] enable_changed;
	logic [IDX_W-1:0]   src_idx;
	logic               src_enabled;
	logic               src_full;
	logic [SUM_W-1:0]   pos_sum;
	logic [PTR_W-1:0]   wr_pos;
	logic               cnt_active;
	logic               cnt_last;
	logic               out_load;
	logic               ram_wr_en;
	logic [MEM_AW-1:0]  ram_wr_addr;
	logic               ram_rd_en;
	logic [MEM_AW-1:0]  ram_rd_addr;
	logic [SAMPLE_W-1:0] ram_rd_data;
	mac_ctl_t           mac_ctl;
	sample_t            mac_acc;

	assign cfg_ready      = 1'b1;
	assign cfg_accept     = cfg_valid && cfg_ready;
	assign enable_write   = cfg_accept && (cfg_index == REG_ENABLE);
	assign enable_changed = cfg_data[GAIN_REGS-1:0] ^ enable_q;
	assign item_stall     = (state_q != S_IDLE);
	assign item_accept    = item_valid && (state_q == S_IDLE);

	// push target checks and write position in the ring
	always_comb begin
		src_idx     = src_q[IDX_W-1:0];
		src_enabled = (32'(src_q) < NUM_ACT) && enable_q[src_q];
		src_full    = src_enabled && (fill_q[src_idx] == CNT_W'(QUEUE_DEPTH));
		pos_sum     = SUM_W'(rp_q[src_idx]) + SUM_W'(fill_q[src_idx]);
		if (pos_sum >= SUM_W'(QUEUE_DEPTH)) begin
			pos_sum = pos_sum - SUM_W'(QUEUE_DEPTH);
		end
		wr_pos = pos_sum[PTR_W-1:0];
	end

	// scan of the source currently under the sequencer
	assign cnt_active = enable_q[cnt_q] && (fill_q[cnt_q] != '0);
	assign cnt_last   = (cnt_q == LAST_IDX);

	// queue ram ports
	assign ram_wr_en   = (state_q == S_PUSH) && src_enabled && !src_full;
	assign ram_wr_addr = MEM_AW'(src_idx * QUEUE_DEPTH) + MEM_AW'(wr_pos);
	assign ram_rd_en   = (state_q == S_SCAN) && cnt_active;
	assign ram_rd_addr = MEM_AW'(cnt_q * QUEUE_DEPTH) + MEM_AW'(rp_q[cnt_q]);

	qspm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MEM_DEPTH)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (smp_q),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// mac sequencing
	always_comb begin
		mac_ctl.acc_clr = item_accept;
		mac_ctl.mul_en  = (state_q == S_READ);
		mac_ctl.acc_en  = (state_q == S_ADD);
	end

	qspm_mac u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.sample (ram_rd_data),
		.gain   (gain_q[cnt_q]),
		.acc    (mac_acc)
	);

	assign out_load = (state_q == S_DONE) && (!result_valid_q || !result_stall);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (item_valid) begin
						unique case (opcode)
							OP_PUSH: state_q <= S_PUSH;
							OP_MIX:  state_q <= S_SCAN;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PUSH: state_q <= S_DONE;
				S_SCAN: begin
					if (cnt_active) begin
						state_q <= S_READ;
					end else if (cnt_last) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_READ: state_q <= S_ADD;
				S_ADD: begin
					if (cnt_last) begin
						state_q <= S_DONE;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// captured item and push status
	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_q         <= opcode;
			src_q        <= source_index;
			smp_q        <= sample_in;
			res_status_q <= STAT_OK;
		end else if (state_q == S_PUSH) begin
			if (!src_enabled) begin
				res_status_q <= STAT_DISABLED;
			end else if (src_full) begin
				res_status_q <= STAT_FULL;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mixed_q  <= (op_q == OP_MIX) ? mac_acc : '0;
			status_q <= res_status_q;
		end
	end

	assign result_valid = result_valid_q;
	assign mixed_sample = mixed_q;
	assign status       = status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < GAIN_REGS; g++) begin
				gain_q[g] <= GAIN_UNITY;
			end
			enable_q <= '0;
		end else if (cfg_accept) begin
			if (cfg_index < CFG_IDX_W'(GAIN_REGS)) begin
				gain_q[cfg_index[GAIN_IDX_W-1:0]] <= cfg_data[GAIN_W-1:0];
			end else if (enable_write) begin
				enable_q <= cfg_data[GAIN_REGS-1:0];
			end
		end
	end

	// queue pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_ACT; s++) begin
				rp_q[s]   <= '0;
				fill_q[s] <= '0;
			end
		end else begin
			for (int s = 0; s < NUM_ACT; s++) begin
				if ((enable_write && enable_changed[s]) ||
					(item_accept && (opcode == OP_FLUSH))) begin
					rp_q[s]   <= '0;
					fill_q[s] <= '0;
				end else if (ram_wr_en && (src_idx == IDX_W'(s))) begin
					fill_q[s] <= fill_q[s] + 1'b1;
				end else if (ram_rd_en && (cnt_q == IDX_W'(s))) begin
					fill_q[s] <= fill_q[s] - 1'b1;
					if (rp_q[s] == PTR_W'(QUEUE_DEPTH - 1)) begin
						rp_q[s] <= '0;
					end else begin
						rp_q[s] <= rp_q[s] + 1'b1;
					end
				end
			end
		end
	end

	// checks
	`QSPM_ASSERT_NEXT(a_read_then_add, clk, arst_n, state_q == S_READ, state_q == S_ADD)
	`QSPM_ASSERT_IMPL(a_push_has_room, clk, arst_n, ram_wr_en, fill_q[src_idx] != CNT_W'(QUEUE_DEPTH))
	`QSPM_ASSERT_IMPL(a_pop_has_data, clk, arst_n, ram_rd_en, fill_q[cnt_q] != '0)
	`QSPM_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, item_valid && !item_stall, state_q != S_IDLE)

endmodule

`default_nettype wire

// ----- rtl/core/qspm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies; holds all source queues of the mixer
`default_nettype none

module qspm_ram #(
	parameter int unsigned WIDTH  = 16,
	parameter int unsigned DEPTH  = 1024,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/qspm_mac.sv -----
// shared multiply, truncate-toward-zero scale and saturating accumulate
// depends on qspm_pkg; one product per sequencer step
`default_nettype none

module qspm_mac
	import qspm_pkg::*;
(
	input  logic              clk,
	input  mac_ctl_t          ctl,
	input  sample_t           sample,
	input  logic [GAIN_W-1:0] gain,
	output sample_t           acc
);

	localparam int unsigned PROD_W = SAMPLE_W + GAIN_W + 1;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] biased;
	logic signed [PROD_W-1:0] scaled;
	logic signed [PROD_W-1:0] sum;
	sample_t                  sat;
	sample_t                  acc_q;

	// signed sample times unsigned gain
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= sample * $signed({1'b0, gain});
		end
	end

	// divide by 4096 toward zero: bias negatives before the arithmetic shift
	always_comb begin
		biased = prod_s1 + $signed({{(PROD_W-GAIN_FRAC){1'b0}},
			{GAIN_FRAC{prod_s1[PROD_W-1]}}});
		scaled = biased >>> GAIN_FRAC;
		sum    = scaled + PROD_W'(acc_q);
		if (sum > PROD_W'(SAMPLE_MAX)) begin
			sat = SAMPLE_MAX;
		end else if (sum < PROD_W'(SAMPLE_MIN)) begin
			sat = SAMPLE_MIN;
		end else begin
			sat = sum[SAMPLE_W-1:0];
		end
	end

	// running mix
	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= sat;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench for queued_saturating_pcm_mixer: directed and random item traffic
// with its own mixer predictor, random idling, backpressure and register phases
// depends on qspm_pkg and the mixer rtl only

module testbench;
	import qspm_pkg::*;

	localparam int unsigned NSRC        = 4;
	localparam int unsigned QDEPTH      = 256;
	localparam int unsigned HALF_PERIOD = 5;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_ITEMS = 70;
	localparam int unsigned RANDOM_PHASES = 7;
	localparam longint GAIN_ONE = longint'(1) << GAIN_FRAC;

	// codes the package leaves unnamed
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		sample_t    smp;
		logic [1:0] st;
	} mix_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic item_valid;
	logic item_stall;
	logic [1:0] opcode;
	logic [1:0] source_index;
	sample_t sample_in;
	logic result_valid;
	logic result_stall;
	sample_t mixed_sample;
	logic [1:0] status;

	// predictor state
	sample_t q_model [NSRC][QDEPTH];
	int unsigned rd_model [NSRC];
	int unsigned cnt_model [NSRC];
	logic [GAIN_W-1:0] gain_model [GAIN_REGS];
	logic [NSRC-1:0] en_model;

	mix_result_t pending_mix [$];
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned quiet_cycles = 0;

	// idling controls: gap for the sender, stall and hold for the receiver
	int unsigned gap_max = 0;
	int unsigned stall_max = 0;
	int unsigned hold_cycles = 0;

	queued_saturating_pcm_mixer #(
		.NUM_SOURCES(NSRC),
		.QUEUE_DEPTH(QDEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.source_index(source_index),
		.sample_in(sample_in),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.mixed_sample(mixed_sample),
		.status(status)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// register write as seen by the predictor
	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
		logic [NSRC-1:0] changed;
		if (idx < GAIN_REGS) begin
			gain_model[idx[GAIN_IDX_W-1:0]] = data[GAIN_W-1:0];
		end else if (idx == REG_ENABLE) begin
			changed = data[NSRC-1:0] ^ en_model;
			// a source added or removed starts with an empty queue
			for (int s = 0; s < NSRC; s++) begin
				if (changed[s]) begin
					rd_model[s] = 0;
					cnt_model[s] = 0;
				end
			end
			en_model = data[NSRC-1:0];
		end
	endfunction

	// one item through the mixer, returns the result it causes
	function automatic mix_result_t mixer_step(logic [1:0] op, logic [1:0] src, sample_t smp);
		mix_result_t r;
		longint acc;
		longint prod;
		int unsigned pos;
		r.smp = '0;
		r.st = STAT_OK;
		acc = 0;
		case (op)
			OP_PUSH: begin
				if (!en_model[src]) begin
					r.st = STAT_DISABLED;
				end else if (cnt_model[src] >= QDEPTH) begin
					r.st = STAT_FULL;
				end else begin
					pos = (rd_model[src] + cnt_model[src]) % QDEPTH;
					q_model[src][pos] = smp;
					cnt_model[src]++;
				end
			end
			OP_MIX: begin
				// source order, saturate after every addition
				for (int s = 0; s < NSRC; s++) begin
					if (en_model[s] && cnt_model[s] != 0) begin
						prod = longint'(q_model[s][rd_model[s]]) * longint'(gain_model[s]);
						prod = prod / GAIN_ONE;
						acc = acc + prod;
						if (acc > longint'(SAMPLE_MAX))
							acc = longint'(SAMPLE_MAX);
						if (acc < longint'(SAMPLE_MIN))
							acc = longint'(SAMPLE_MIN);
						rd_model[s] = (rd_model[s] + 1) % QDEPTH;
						cnt_model[s]--;
					end
				end
				r.smp = sample_t'(acc);
			end
			OP_FLUSH: begin
				for (int s = 0; s < NSRC; s++) begin
					rd_model[s] = 0;
					cnt_model[s] = 0;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return GAIN_UNITY;
			3: return GAIN_W'($urandom_range(8191));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// beat monitor: checks results, predicts items, tracks register writes
	always @(posedge clk) begin : beat_monitor
		mix_result_t want;
		logic beat;
		beat = 1'b0;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				beat = 1'b1;
				results_seen++;
				if (pending_mix.size() == 0) begin
					$display("%0t: result with nothing pending: expected none, actual %0d / %0d",
						$time, $signed(mixed_sample), status);
					errors++;
				end else begin
					want = pending_mix.pop_front();
					if (mixed_sample !== want.smp) begin
						$display("%0t: mixed_sample mismatch: expected %0d, actual %0d",
							$time, $signed(want.smp), $signed(mixed_sample));
						errors++;
					end
					if (status !== want.st) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.st, status);
						errors++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				beat = 1'b1;
				items_sent++;
				pending_mix.push_back(mixer_step(opcode, source_index, sample_in));
			end
			if (cfg_valid && cfg_ready) begin
				beat = 1'b1;
				reg_writes++;
				apply_reg_write(cfg_index, cfg_data);
			end
			quiet_cycles <= beat ? 0 : quiet_cycles + 1;
		end
	end

	// watchdog on cycles without any beat
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	// result receiver: random stall before each beat, or a long hold on request
	initial begin : result_sink
		int unsigned n;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			n = (stall_max == 0) ? 0 : $urandom_range(stall_max);
			if (hold_cycles != 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
			@(negedge clk);
		end
	end

	// one item beat; called and returns at a falling edge
	task automatic send_item(input logic [1:0] op, input logic [1:0] src, input sample_t smp);
		int unsigned gap;
		gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		source_index <= src;
		sample_in <= smp;
		do @(posedge clk); while (!(item_valid && !item_stall));
		@(negedge clk);
	endtask

	// one register write beat
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop offering items and wait until every result is back
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// after reset: all sources disabled, gains at unity
	task automatic test_after_reset();
		gap_max = 19;
		stall_max = 19;
		send_item(OP_PUSH, 2'd0, SAMPLE_MAX);
		send_item(OP_PUSH, 2'd1, SAMPLE_MIN);
		send_item(OP_PUSH, 2'd2, sample_t'(16'h5555));
		send_item(OP_PUSH, 2'd3, sample_t'(16'hAAAA));
		send_item(OP_MIX, 2'd3, sample_t'(16'hFFFF));
		send_item(OP_UNUSED, 2'd2, SAMPLE_MAX);
		send_item(OP_FLUSH, 2'd1, SAMPLE_MIN);
	endtask

	// gain extremes, truncation toward zero, saturation order
	task automatic test_gain_and_saturation();
		wait_idle();
		write_reg(REG_ENABLE, 16'h000F);
		// positive saturation first, then a negative term pulls it back
		send_item(OP_PUSH, 2'd0, SAMPLE_MAX);
		send_item(OP_PUSH, 2'd1, SAMPLE_MAX);
		send_item(OP_PUSH, 2'd2, SAMPLE_MIN);
		send_item(OP_PUSH, 2'd3, sample_t'(0));
		send_item(OP_MIX, 2'd0, sample_t'(0));
		wait_idle();
		write_reg(REG_GAIN0, 16'hFFFF);
		write_reg(REG_GAIN0 + CFG_IDX_W'(1), 16'h0000);
		write_reg(REG_GAIN0 + CFG_IDX_W'(2), 16'h0001);
		write_reg(REG_GAIN0 + CFG_IDX_W'(3), GAIN_UNITY);
		send_item(OP_PUSH, 2'd0, SAMPLE_MIN);
		send_item(OP_PUSH, 2'd1, SAMPLE_MAX);
		send_item(OP_PUSH, 2'd2, sample_t'(-1));
		send_item(OP_PUSH, 2'd3, SAMPLE_MIN);
		send_item(OP_MIX, 2'd1, sample_t'(0));
		// small positive and negative products truncate toward zero
		send_item(OP_PUSH, 2'd2, sample_t'(-4097));
		send_item(OP_PUSH, 2'd0, sample_t'(3));
		send_item(OP_MIX, 2'd2, sample_t'(0));
		send_item(OP_MIX, 2'd3, sample_t'(0));
	endtask

	// enable toggles empty the affected queue only
	task automatic test_enable_change();
		send_item(OP_PUSH, 2'd1, sample_t'(100));
		send_item(OP_PUSH, 2'd3, sample_t'(-200));
		wait_idle();
		write_reg(REG_ENABLE, 16'h000D);
		write_reg(REG_ENABLE, 16'hFFFF);
		send_item(OP_PUSH, 2'd1, sample_t'(7));
		send_item(OP_MIX, 2'd0, sample_t'(0));
		send_item(OP_MIX, 2'd0, sample_t'(0));
	endtask

	// fill one queue to the top, wrap both pointers, then flush
	task automatic test_queue_full();
		wait_idle();
		write_reg(REG_GAIN0 + CFG_IDX_W'(2), GAIN_UNITY);
		write_reg(REG_ENABLE, 16'h0004);
		gap_max = 0;
		stall_max = 0;
		repeat (QDEPTH) send_item(OP_PUSH, 2'd2, pick_sample());
		send_item(OP_PUSH, 2'd2, sample_t'(16'h1234));
		send_item(OP_PUSH, 2'd1, pick_sample());
		repeat (20) send_item(OP_MIX, 2'($urandom), sample_t'($urandom));
		repeat (20) send_item(OP_PUSH, 2'd2, pick_sample());
		send_item(OP_PUSH, 2'd2, pick_sample());
		repeat (QDEPTH) send_item(OP_MIX, 2'($urandom), sample_t'($urandom));
		send_item(OP_MIX, 2'd0, sample_t'(0));
		gap_max = 19;
		stall_max = 19;
		repeat (5) send_item(OP_PUSH, 2'd2, pick_sample());
		send_item(OP_FLUSH, 2'($urandom), sample_t'($urandom));
		send_item(OP_MIX, 2'd0, sample_t'(0));
	endtask

	// receiver holds off while the sender keeps offering, then sender waits for drain
	task automatic test_backpressure();
		wait_idle();
		write_reg(REG_ENABLE, 16'h000F);
		gap_max = 0;
		stall_max = 0;
		hold_cycles = 300;
		repeat (30) send_item(OP_PUSH, 2'($urandom), pick_sample());
		repeat (10) send_item(OP_MIX, 2'($urandom), sample_t'($urandom));
		wait_idle();
		gap_max = 19;
		stall_max = 19;
		repeat (10) begin
			send_item(OP_PUSH, 2'($urandom), pick_sample());
			send_item(OP_MIX, 2'($urandom), sample_t'($urandom));
		end
	endtask

	// random phases under different gains, enables and idling
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned ph;
		int unsigned i;
		int unsigned r;
		int unsigned tries;
		logic [NSRC-1:0] cur_en;
		logic [1:0] src;
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			for (i = 0; i < GAIN_REGS; i++)
				write_reg(REG_GAIN0 + CFG_IDX_W'(i), pick_gain());
			if (ph == 0)
				cur_en = '1;
			else if (ph == 1)
				cur_en = NSRC'(1) << $urandom_range(NSRC - 1);
			else
				cur_en = NSRC'($urandom_range(15, 1));
			write_reg(REG_ENABLE, (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(15)) |
				CFG_DATA_W'(cur_en));
			if (ph == 2) begin
				write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
			end
			// some phases run with no idling at all, some with one side only
			case (ph % 3)
				0: begin
					gap_max = 0;
					stall_max = 0;
				end
				1: begin
					gap_max = 19;
					stall_max = 19;
				end
				default: begin
					gap_max = (ph > 3) ? 0 : 19;
					stall_max = (ph > 3) ? 19 : 0;
				end
			endcase
			for (i = 0; i < n_items / RANDOM_PHASES; i++) begin
				r = $urandom_range(99);
				if (r < 45) begin
					src = 2'($urandom);
					tries = 0;
					while (!cur_en[src] && tries < 8) begin
						src = 2'($urandom);
						tries++;
					end
					send_item(OP_PUSH, src, pick_sample());
				end else if (r < 80) begin
					send_item(OP_MIX, 2'($urandom), sample_t'($urandom));
				end else if (r < 92) begin
					send_item(OP_PUSH, 2'($urandom), pick_sample());
				end else if (r < 96) begin
					send_item(OP_FLUSH, 2'($urandom), sample_t'($urandom));
				end else begin
					send_item(OP_UNUSED, 2'($urandom), sample_t'($urandom));
				end
			end
		end
	endtask

	initial begin : main_sequence
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		opcode = OP_PUSH;
		source_index = '0;
		sample_in = '0;
		// predictor reset state
		for (int s = 0; s < NSRC; s++) begin
			rd_model[s] = 0;
			cnt_model[s] = 0;
			gain_model[s] = GAIN_UNITY;
		end
		en_model = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_after_reset();
		test_gain_and_saturation();
		test_enable_change();
		test_queue_full();
		test_backpressure();
		test_random_traffic(RANDOM_ITEMS);

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_mix.size() != 0) begin
			$display("%0t: results missing: expected %0d more, actual 0",
				$time, pending_mix.size());
			errors++;
		end
		$display("run covered %0d items, %0d results and %0d register writes", items_sent,
			results_seen, reg_writes);
		$display("phases: reset state, gains and saturation, enable toggles, full queue, "
			, "backpressure, random traffic; %0d mismatches", errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
